@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the sky dome texture coordinate RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sdtg_pkg.sv @@
// ----------------------------------------------------------------------------
// sdtg_pkg
// Widths, constants and shared types of the sky dome texture coordinate block
// ----------------------------------------------------------------------------
`default_nettype none
package sdtg_pkg;
  // field widths
  localparam int IN_W       = 20;
  localparam int DIFF_W     = 21;
  localparam int VEC_W      = 23;
  localparam int MAG_W      = 22;
  localparam int SHIFT_W    = 5;
  localparam int SQ_W       = 44;
  localparam int SUM_W      = 46;
  localparam int LEN_W      = 23;
  localparam int SCR_W      = 15;
  localparam int NUM_W      = 40;
  localparam int QHEAD_W    = 17;
  localparam int RND_SHIFT  = 15;
  localparam int OUT_W      = 15;
  localparam int RADIUS_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // sky radius 6*63, scroll fraction bits
  localparam int RADIUS_NUM = 378;
  localparam int SCR_FRAC   = 8;

  // output clamp
  localparam int OUT_MAX     = 16383;
  localparam int OUT_MIN_MAG = 16384;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL = 2'd3;

  // normalized horizontal direction and zero-length flag
  typedef struct packed {
    logic signed [VEC_W-1:0] cx;
    logic signed [VEC_W-1:0] cy;
    logic                    zero;
  } dir_t;
endpackage
`default_nettype wire

@@ rtl/sdtg_front.sv @@
// ----------------------------------------------------------------------------
// sdtg_front
// Eye-relative direction, vertical stretch, normalization and squared length
// ----------------------------------------------------------------------------
`default_nettype none
module sdtg_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]      vert_x,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]      vert_y,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]      vert_z,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]      eye_x,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]      eye_y,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]      eye_z,
  output logic                                        out_valid,
  output sdtg_pkg::dir_t                              dir,
  output logic [sdtg_pkg::SUM_W-1:0]                  sum_sq
);
  localparam int DW = sdtg_pkg::DIFF_W;
  localparam int VW = sdtg_pkg::VEC_W;
  localparam int MW = sdtg_pkg::MAG_W;
  localparam int NW = sdtg_pkg::SHIFT_W;
  localparam int QW = sdtg_pkg::SQ_W;
  localparam int SW = sdtg_pkg::SUM_W;

  function automatic logic [MW-1:0] abs_v(logic signed [VW-1:0] v);
    return MW'(v < 0 ? -v : v);
  endfunction

  // position of the leading one, as a left shift to bit MW-1
  function automatic logic [NW-1:0] lead_shift(logic [MW-1:0] m);
    logic [NW-1:0] n;
    n = '0;
    for (int i = 0; i < MW; i++) begin
      if (m[i]) n = NW'(MW - 1 - i);
    end
    return n;
  endfunction

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dz1_r;
  logic signed [VW-1:0] vx2_r, vy2_r;
  logic [MW-1:0]        ax2_r, ay2_r, az2_r;
  logic signed [VW-1:0] vx3_r, vy3_r;
  logic [MW-1:0]        ax3_r, ay3_r, az3_r;
  logic [NW-1:0]        n3_r;
  logic                 z3_r;
  logic signed [VW-1:0] vx4_r, vy4_r;
  logic [MW-1:0]        ax4_r, ay4_r, az4_r;
  logic                 z4_r;
  logic signed [VW-1:0] vx5_r, vy5_r;
  logic [QW-1:0]        qx5_r, qy5_r, qz5_r;
  logic                 z5_r;
  logic signed [VW-1:0] vx6_r, vy6_r;
  logic [SW-1:0]        sum6_r;
  logic                 z6_r;

  logic signed [VW-1:0] dz3;
  logic [MW-1:0]        mx;

  assign dz3 = (VW'(dz1_r) <<< 1) + VW'(dz1_r);
  assign mx  = (ax2_r > ay2_r) ? ((ax2_r > az2_r) ? ax2_r : az2_r)
                               : ((ay2_r > az2_r) ? ay2_r : az2_r);

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      // eye-relative difference
      dx1_r <= DW'(vert_x) - DW'(eye_x);
      dy1_r <= DW'(vert_y) - DW'(eye_y);
      dz1_r <= DW'(vert_z) - DW'(eye_z);
      // tripled vertical, magnitudes
      vx2_r <= VW'(dx1_r);
      vy2_r <= VW'(dy1_r);
      ax2_r <= abs_v(VW'(dx1_r));
      ay2_r <= abs_v(VW'(dy1_r));
      az2_r <= abs_v(dz3);
      // largest magnitude and its normalizing shift
      vx3_r <= vx2_r;
      vy3_r <= vy2_r;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      az3_r <= az2_r;
      n3_r  <= lead_shift(mx);
      z3_r  <= (mx == '0);
      // normalize
      vx4_r <= vx3_r <<< n3_r;
      vy4_r <= vy3_r <<< n3_r;
      ax4_r <= ax3_r << n3_r;
      ay4_r <= ay3_r << n3_r;
      az4_r <= az3_r << n3_r;
      z4_r  <= z3_r;
      // squares
      vx5_r <= vx4_r;
      vy5_r <= vy4_r;
      qx5_r <= QW'(ax4_r) * QW'(ax4_r);
      qy5_r <= QW'(ay4_r) * QW'(ay4_r);
      qz5_r <= QW'(az4_r) * QW'(az4_r);
      z5_r  <= z4_r;
      // sum of squares
      vx6_r  <= vx5_r;
      vy6_r  <= vy5_r;
      sum6_r <= SW'(qx5_r) + SW'(qy5_r) + SW'(qz5_r);
      z6_r   <= z5_r;
    end
  end

  assign out_valid = v6_r;
  assign dir.cx    = vx6_r;
  assign dir.cy    = vy6_r;
  assign dir.zero  = z6_r;
  assign sum_sq    = sum6_r;
endmodule
`default_nettype wire

@@ rtl/sdtg_sqrt.sv @@
// ----------------------------------------------------------------------------
// sdtg_sqrt
// Pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module sdtg_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [sdtg_pkg::SUM_W-1:0]   sum_sq,
  input  wire sdtg_pkg::dir_t               dir_in,
  output logic                              out_valid,
  output logic [sdtg_pkg::LEN_W-1:0]        root,
  output sdtg_pkg::dir_t                    dir_out
);
  localparam int LW = sdtg_pkg::LEN_W;
  localparam int SW = sdtg_pkg::SUM_W;
  localparam int RW = LW + 3;

  logic                 vld_r  [LW];
  logic [RW-1:0]        rem_r  [LW];
  logic [LW-1:0]        root_r [LW];
  logic [SW-1:0]        rad_r  [LW];
  sdtg_pkg::dir_t       dir_r  [LW];

  for (genvar k = 0; k < LW; k++) begin : g_stage
    logic           vld_p;
    logic [RW-1:0]  rem_p;
    logic [LW-1:0]  root_p;
    logic [SW-1:0]  rad_p;
    sdtg_pkg::dir_t dir_p;
    logic [RW-1:0]  t_in;
    logic [RW-1:0]  trial;

    if (k == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = sum_sq;
      assign dir_p  = dir_in;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign dir_p  = dir_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign t_in  = {rem_p[RW-3:0], rad_p[SW-1 -: 2]};
    assign trial = RW'({root_p, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (t_in >= trial) begin
          rem_r[k]  <= t_in - trial;
          root_r[k] <= {root_p[LW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= t_in;
          root_r[k] <= {root_p[LW-2:0], 1'b0};
        end
        rad_r[k] <= rad_p << 2;
        dir_r[k] <= dir_p;
      end
    end
  end

  assign out_valid = vld_r[LW-1];
  assign root      = root_r[LW-1];
  assign dir_out   = dir_r[LW-1];
endmodule
`default_nettype wire

@@ rtl/sdtg_numer.sv @@
// ----------------------------------------------------------------------------
// sdtg_numer
// Dividend build: scroll times length plus scaled direction, sign split
// ----------------------------------------------------------------------------
`default_nettype none
module sdtg_numer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [sdtg_pkg::LEN_W-1:0]   root,
  input  wire sdtg_pkg::dir_t               dir,
  input  wire logic [sdtg_pkg::SCR_W-1:0]   scroll,
  output logic                              out_valid,
  output logic [sdtg_pkg::LEN_W-1:0]        len,
  output logic [sdtg_pkg::NUM_W-1:0]        mag_x,
  output logic [sdtg_pkg::NUM_W-1:0]        mag_y,
  output logic                              neg_x,
  output logic                              neg_y
);
  localparam int LW = sdtg_pkg::LEN_W;
  localparam int NW = sdtg_pkg::NUM_W;
  localparam int KW = sdtg_pkg::RADIUS_W;
  localparam int PW = LW + sdtg_pkg::SCR_W;

  logic                 v1_r, v2_r, v3_r;
  logic [LW-1:0]        len1_r, len2_r, len3_r;
  logic [PW-1:0]        ps1_r;
  logic signed [KW-1:0] kx1_r, ky1_r;
  logic signed [NW:0]   nx2_r, ny2_r;
  logic [NW-1:0]        mx3_r, my3_r;
  logic                 sx3_r, sy3_r;
  logic [LW-1:0]        len_sel;

  // zero-length direction divides by one
  assign len_sel = dir.zero ? LW'(1) : root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      len1_r <= len_sel;
      ps1_r  <= PW'(len_sel) * PW'(scroll);
      kx1_r  <= KW'(dir.cx) * KW'(sdtg_pkg::RADIUS_NUM);
      ky1_r  <= KW'(dir.cy) * KW'(sdtg_pkg::RADIUS_NUM);
      // signed sum
      len2_r <= len1_r;
      nx2_r  <= $signed((NW+1)'(ps1_r)) + ((NW+1)'(kx1_r) <<< sdtg_pkg::SCR_FRAC);
      ny2_r  <= $signed((NW+1)'(ps1_r)) + ((NW+1)'(ky1_r) <<< sdtg_pkg::SCR_FRAC);
      // sign and magnitude
      len3_r <= len2_r;
      sx3_r  <= nx2_r < 0;
      sy3_r  <= ny2_r < 0;
      mx3_r  <= NW'(nx2_r < 0 ? -nx2_r : nx2_r);
      my3_r  <= NW'(ny2_r < 0 ? -ny2_r : ny2_r);
    end
  end

  assign out_valid = v3_r;
  assign len       = len3_r;
  assign mag_x     = mx3_r;
  assign mag_y     = my3_r;
  assign neg_x     = sx3_r;
  assign neg_y     = sy3_r;
endmodule
`default_nettype wire

@@ rtl/sdtg_div.sv @@
// ----------------------------------------------------------------------------
// sdtg_div
// Pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module sdtg_div #(
  parameter int TEX_FRAC_BITS = 12
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           en,
  input  wire logic                                           in_valid,
  input  wire logic [sdtg_pkg::NUM_W-1:0]                     num,
  input  wire logic [sdtg_pkg::LEN_W-1:0]                     den,
  input  wire logic                                           neg_in,
  output logic                                                out_valid,
  output logic [sdtg_pkg::QHEAD_W+TEX_FRAC_BITS-1:0]          quot,
  output logic                                                neg_out
);
  localparam int LW = sdtg_pkg::LEN_W;
  localparam int HW = sdtg_pkg::QHEAD_W;
  localparam int QW = HW + TEX_FRAC_BITS;

  logic          vld_r [QW];
  logic [LW-1:0] rem_r [QW];
  logic [QW-1:0] acc_r [QW];
  logic [LW-1:0] den_r [QW];
  logic          neg_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_p;
    logic [LW-1:0] rem_p;
    logic [QW-1:0] acc_p;
    logic [LW-1:0] den_p;
    logic          neg_p;
    logic [LW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      // dividend is num shifted up by the texture fraction bits
      assign vld_p = in_valid;
      assign rem_p = LW'(num >> HW);
      assign acc_p = {num[HW-1:0], {TEX_FRAC_BITS{1'b0}}};
      assign den_p = den;
      assign neg_p = neg_in;
    end else begin : g_next
      assign vld_p = vld_r[k-1];
      assign rem_p = rem_r[k-1];
      assign acc_p = acc_r[k-1];
      assign den_p = den_r[k-1];
      assign neg_p = neg_r[k-1];
    end

    assign t  = {rem_p, acc_p[QW-1]};
    assign ge = t >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? LW'(t - {1'b0, den_p}) : t[LW-1:0];
        acc_r[k] <= {acc_p[QW-2:0], ge};
        den_r[k] <= den_p;
        neg_r[k] <= neg_p;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quot      = acc_r[QW-1];
  assign neg_out   = neg_r[QW-1];
endmodule
`default_nettype wire

@@ rtl/sky_dome_texcoord_gen_core.sv @@
// ----------------------------------------------------------------------------
// sky_dome_texcoord_gen_core
// Sky dome texture coordinates from one polygon vertex per word
// ----------------------------------------------------------------------------
// Input words carry a vertex position (Q15.4); each gives one output word
// with the s and t sky coordinates (Q10.5, saturated). The user must
// write eye position and scroll offset through the cfg port while the
// block is idle; the block does not enforce this. Both channels move a
// word on a clock edge with valid high and stall low. Throughput: one
// word per cycle unless the output stalls. Input words pass the 23-stage
// square root and the (17 + TEX_FRAC_BITS)-stage divider pipelines.
// When the receiver stalls, the next finished word drops into a skid
// register; in_stall rises with it and the whole pipeline holds
// until the skid word moves to the output register.
// Reset (synchronous, active low) clears all valid bits and the eye and
// scroll registers to zero; the block accepts words once reset ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sky_dome_texcoord_gen_core #(
  parameter int TEX_FRAC_BITS = 12
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  // configuration
  input  wire logic                                     cfg_we,
  input  wire logic [sdtg_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [sdtg_pkg::CFG_DATA_W-1:0]          cfg_data,
  // vertex input
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]         in_vert_x,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]         in_vert_y,
  input  wire logic signed [sdtg_pkg::IN_W-1:0]         in_vert_z,
  // texture coordinate output
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic signed [sdtg_pkg::OUT_W-1:0]             out_tex_s,
  output logic signed [sdtg_pkg::OUT_W-1:0]             out_tex_t
);
  localparam int OW = sdtg_pkg::OUT_W;
  localparam int QW = sdtg_pkg::QHEAD_W + TEX_FRAC_BITS;
  localparam int MW = QW + 1 - sdtg_pkg::RND_SHIFT;
  localparam int EW = (MW > OW) ? MW : OW + 1;

  // configuration registers
  logic signed [sdtg_pkg::IN_W-1:0] eye_x_r, eye_y_r, eye_z_r;
  logic [sdtg_pkg::SCR_W-1:0]       scroll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r  <= '0;
      eye_y_r  <= '0;
      eye_z_r  <= '0;
      scroll_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdtg_pkg::CFG_EYE_X:  eye_x_r  <= cfg_data;
        sdtg_pkg::CFG_EYE_Y:  eye_y_r  <= cfg_data;
        sdtg_pkg::CFG_EYE_Z:  eye_z_r  <= cfg_data;
        sdtg_pkg::CFG_SCROLL: scroll_r <= cfg_data[sdtg_pkg::SCR_W-1:0];
      endcase
    end
  end

  // pipeline advances while the skid register is empty
  logic skid_valid_r;
  logic en;
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  logic                             f_valid;
  sdtg_pkg::dir_t                   f_dir;
  logic [sdtg_pkg::SUM_W-1:0]       f_sum;
  logic                             r_valid;
  logic [sdtg_pkg::LEN_W-1:0]       r_root;
  sdtg_pkg::dir_t                   r_dir;
  logic                             n_valid;
  logic [sdtg_pkg::LEN_W-1:0]       n_len;
  logic [sdtg_pkg::NUM_W-1:0]       n_mag_x, n_mag_y;
  logic                             n_neg_x, n_neg_y;
  logic                             dx_valid, dy_valid;
  logic [QW-1:0]                    qx, qy;
  logic                             qx_neg, qy_neg;

  sdtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .vert_x    (in_vert_x),
    .vert_y    (in_vert_y),
    .vert_z    (in_vert_z),
    .eye_x     (eye_x_r),
    .eye_y     (eye_y_r),
    .eye_z     (eye_z_r),
    .out_valid (f_valid),
    .dir       (f_dir),
    .sum_sq    (f_sum)
  );

  sdtg_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .sum_sq    (f_sum),
    .dir_in    (f_dir),
    .out_valid (r_valid),
    .root      (r_root),
    .dir_out   (r_dir)
  );

  sdtg_numer u_numer (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (r_valid),
    .root      (r_root),
    .dir       (r_dir),
    .scroll    (scroll_r),
    .out_valid (n_valid),
    .len       (n_len),
    .mag_x     (n_mag_x),
    .mag_y     (n_mag_y),
    .neg_x     (n_neg_x),
    .neg_y     (n_neg_y)
  );

  sdtg_div #(.TEX_FRAC_BITS(TEX_FRAC_BITS)) u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n_valid),
    .num       (n_mag_x),
    .den       (n_len),
    .neg_in    (n_neg_x),
    .out_valid (dx_valid),
    .quot      (qx),
    .neg_out   (qx_neg)
  );

  sdtg_div #(.TEX_FRAC_BITS(TEX_FRAC_BITS)) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n_valid),
    .num       (n_mag_y),
    .den       (n_len),
    .neg_in    (n_neg_y),
    .out_valid (dy_valid),
    .quot      (qy),
    .neg_out   (qy_neg)
  );

  // round half away from zero, then clamp and apply sign
  function automatic logic [OW-1:0] sat_coord(logic [QW-1:0] q, logic neg);
    logic [QW:0]   rnd;
    logic [EW-1:0] mag;
    logic [EW-1:0] lim;
    rnd = (QW+1)'(q) + (QW+1)'(1 << (sdtg_pkg::RND_SHIFT - 1));
    mag = EW'(rnd >> sdtg_pkg::RND_SHIFT);
    lim = mag;
    if (neg) begin
      if (mag > EW'(sdtg_pkg::OUT_MIN_MAG)) lim = EW'(sdtg_pkg::OUT_MIN_MAG);
      return OW'(-lim);
    end else begin
      if (mag > EW'(sdtg_pkg::OUT_MAX)) lim = EW'(sdtg_pkg::OUT_MAX);
      return OW'(lim);
    end
  endfunction

  logic                 p_valid_r;
  logic signed [OW-1:0] p_s_r, p_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= dx_valid & dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_s_r <= sat_coord(qx, qx_neg);
      p_t_r <= sat_coord(qy, qy_neg);
    end
  end

  // output register with skid
  logic                 out_valid_r;
  logic signed [OW-1:0] out_s_r, out_t_r, skid_s_r, skid_t_r;
  logic                 take;
  assign take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= p_valid_r;
      end
    end else if (p_valid_r && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid_r) begin
        out_s_r <= skid_s_r;
        out_t_r <= skid_t_r;
      end else begin
        out_s_r <= p_s_r;
        out_t_r <= p_t_r;
      end
    end else if (!skid_valid_r) begin
      skid_s_r <= p_s_r;
      skid_t_r <= p_t_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tex_s = out_s_r;
  assign out_tex_t = out_t_r;

  // skid only holds a word behind a waiting output word
  `ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // skid word is kept while the output stays blocked
  `ASSERT_NXT(a_skid_kept, clk, rst_n, skid_valid_r && out_valid_r && out_stall, skid_valid_r)
  // finished word is captured when the output is blocked
  `ASSERT_NXT(a_skid_capture, clk, rst_n,
              p_valid_r && !skid_valid_r && out_valid_r && out_stall, skid_valid_r)
  // both coordinate dividers stay in step
  `ASSERT_IMP(a_div_lockstep, clk, rst_n, 1'b1, dx_valid == dy_valid)
endmodule
`default_nettype wire
